// ===== rtl/rlm_pkg.sv =====
// ----------------------------------------------------------------------------
// rlm_pkg
// Shared widths, constants and state type of the block RMS level meter.
// ----------------------------------------------------------------------------
`default_nettype none

package rlm_pkg;

  localparam int unsigned SampleW       = 8;
  localparam int unsigned RmsW          = 16;
  localparam int unsigned LevelW        = 16;
  localparam int unsigned CountOutW     = 13;
  localparam int unsigned MaxBlockDflt  = 4096;
  localparam int unsigned MsqFracW      = 16;
  localparam int unsigned LevelFracW    = 8;
  localparam int unsigned LevelDiv      = 255;
  localparam int unsigned RootSteps     = 16;
  localparam int unsigned QuoW          = 32;
  localparam int unsigned RootRemW      = 18;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_MSQ,
    ST_ROOT,
    ST_LEVEL,
    ST_DONE
  } rlm_state_e;

endpackage

`default_nettype wire

// ===== rtl/rlm_intf.sv =====
// ----------------------------------------------------------------------------
// rlm_intf
// Valid/ready channels of the level meter: sample words in, result words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface rlm_smp_if import rlm_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] sample;
  logic                      last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

interface rlm_res_if import rlm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [RmsW-1:0]      rms_q8;
  logic [LevelW-1:0]    level_q16;
  logic [CountOutW-1:0] sample_count;
  logic                 overflowed;

  modport source (output valid, output rms_q8, output level_q16, output sample_count,
                  output overflowed, input ready);
  modport sink   (input valid, input rms_q8, input level_q16, input sample_count,
                  input overflowed, output ready);
endinterface

`default_nettype wire

// ===== rtl/block_rms_level_meter_core.sv =====
// ----------------------------------------------------------------------------
// block_rms_level_meter_core
// Sum of squares per block, then bit-serial mean square divide, square root
// and level divide, one result word per block.
// ----------------------------------------------------------------------------
//  channel | dir | word                                      | accepted when
//  smp_i   | in  | sample, last                              | valid & ready
//  res_o   | out | rms_q8, level_q16, sample_count, overflowed | valid & ready
//
// A sample word is taken every cycle while a block accumulates.
// After the last word of a block the input stalls through the mean
// square divide, the root steps, the level divide and the result
// load; the shared restoring divider and the root unit set it.
// The result register holds a word until taken; a new block is accepted
// meanwhile and waits in its final cycle only if that word is still there.
// Reset clears the accumulator, the count, the overflow flag and the control.
// ----------------------------------------------------------------------------
`default_nettype none

module block_rms_level_meter_core import rlm_pkg::*; #(
  parameter int unsigned MAX_BLOCK = MaxBlockDflt
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  rlm_smp_if.sink    smp_i,
  rlm_res_if.source  res_o
);

  localparam int unsigned CW  = $clog2(MAX_BLOCK + 1);
  localparam int unsigned SW  = 14 + CW;
  localparam int unsigned DW  = SW + MsqFracW;
  localparam int unsigned DVW = (CW > 8) ? CW : 8;
  localparam int unsigned STW = $clog2(DW + 1);
  localparam int unsigned LDW = RmsW + LevelFracW;

  rlm_state_e state_q, state_d;

  logic [SW-1:0]       acc_sum_q, acc_sum_d;
  logic [CW-1:0]       acc_cnt_q, acc_cnt_d;
  logic                acc_ovf_q, acc_ovf_d;
  logic [CW-1:0]       blk_cnt_q, blk_cnt_d;
  logic                blk_ovf_q, blk_ovf_d;

  logic [DW-1:0]       dvd_q, dvd_d;
  logic [DVW-1:0]      den_q, den_d;
  logic [DVW:0]        rem_q, rem_d;
  logic [QuoW-1:0]     quo_q, quo_d;
  logic [STW-1:0]      step_q, step_d;
  logic [RootRemW-1:0] rrem_q, rrem_d;
  logic [RmsW-1:0]     root_q, root_d;

  logic                res_valid_q, res_valid_d;
  logic [RmsW-1:0]     res_rms_q, res_rms_d;
  logic [LevelW-1:0]   res_lvl_q, res_lvl_d;
  logic [CW-1:0]       res_cnt_q, res_cnt_d;
  logic                res_ovf_q, res_ovf_d;

  logic                smp_acc;
  logic                step_last;
  logic                slot_free;
  logic signed [2*SampleW-1:0] sq;
  logic [SW-1:0]       nxt_sum;
  logic [CW-1:0]       nxt_cnt;
  logic                nxt_ovf;
  logic [DVW:0]        div_sh;
  logic                div_ge;
  logic [RootRemW+1:0] rt_sh;
  logic [RootRemW+1:0] rt_trial;
  logic                rt_ge;
  logic [CW+CountOutW-1:0] cnt_ext;

  assign smp_acc   = smp_i.valid && smp_i.ready;
  assign step_last = (step_q == STW'(1));
  assign slot_free = !res_valid_q || res_o.ready;

  // Accumulate
  assign sq = smp_i.sample * smp_i.sample;
  always_comb begin
    if (acc_cnt_q < CW'(MAX_BLOCK)) begin
      nxt_sum = acc_sum_q + SW'($unsigned(sq));
      nxt_cnt = acc_cnt_q + CW'(1);
      nxt_ovf = acc_ovf_q;
    end else begin
      nxt_sum = acc_sum_q;
      nxt_cnt = acc_cnt_q;
      nxt_ovf = 1'b1;
    end
  end

  // Restoring divide step, one quotient bit per cycle
  assign div_sh = {rem_q[DVW-1:0], dvd_q[DW-1]};
  assign div_ge = (div_sh >= {1'b0, den_q});

  // Square root step, two radicand bits per cycle
  assign rt_sh    = {rrem_q, quo_q[QuoW-1 -: 2]};
  assign rt_trial = {2'b00, root_q, 2'b01};
  assign rt_ge    = (rt_sh >= rt_trial);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_ACC: begin
        if (smp_acc && smp_i.last) state_d = ST_MSQ;
      end
      ST_MSQ: begin
        if (step_last) state_d = ST_ROOT;
      end
      ST_ROOT: begin
        if (step_last) state_d = ST_LEVEL;
      end
      ST_LEVEL: begin
        if (step_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) state_d = ST_ACC;
      end
      default: state_d = ST_ACC;
    endcase
  end

  assign smp_i.ready = (state_q == ST_ACC);

  always_comb begin
    acc_sum_d   = acc_sum_q;
    acc_cnt_d   = acc_cnt_q;
    acc_ovf_d   = acc_ovf_q;
    blk_cnt_d   = blk_cnt_q;
    blk_ovf_d   = blk_ovf_q;
    dvd_d       = dvd_q;
    den_d       = den_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    step_d      = step_q;
    rrem_d      = rrem_q;
    root_d      = root_q;
    res_valid_d = res_valid_q;
    res_rms_d   = res_rms_q;
    res_lvl_d   = res_lvl_q;
    res_cnt_d   = res_cnt_q;
    res_ovf_d   = res_ovf_q;

    if (res_valid_q && res_o.ready) res_valid_d = 1'b0;

    unique case (state_q)
      ST_ACC: begin
        if (smp_acc) begin
          if (smp_i.last) begin
            acc_sum_d = '0;
            acc_cnt_d = '0;
            acc_ovf_d = 1'b0;
            blk_cnt_d = nxt_cnt;
            blk_ovf_d = nxt_ovf;
            dvd_d     = {nxt_sum, {MsqFracW{1'b0}}};
            den_d     = DVW'(nxt_cnt);
            rem_d     = '0;
            quo_d     = '0;
            step_d    = STW'(DW);
          end else begin
            acc_sum_d = nxt_sum;
            acc_cnt_d = nxt_cnt;
            acc_ovf_d = nxt_ovf;
          end
        end
      end
      ST_MSQ, ST_LEVEL: begin
        rem_d  = div_ge ? (div_sh - {1'b0, den_q}) : div_sh;
        quo_d  = {quo_q[QuoW-2:0], div_ge};
        dvd_d  = dvd_q << 1;
        step_d = step_q - STW'(1);
        if (step_last && (state_q == ST_MSQ)) begin
          rrem_d = '0;
          root_d = '0;
          step_d = STW'(RootSteps);
        end
      end
      ST_ROOT: begin
        rrem_d = rt_ge ? RootRemW'(rt_sh - rt_trial) : RootRemW'(rt_sh);
        root_d = {root_q[RmsW-2:0], rt_ge};
        quo_d  = quo_q << 2;
        step_d = step_q - STW'(1);
        if (step_last) begin
          dvd_d              = '0;
          dvd_d[DW-1 -: LDW] = {root_d, {LevelFracW{1'b0}}};
          den_d              = DVW'(LevelDiv);
          rem_d              = '0;
          quo_d              = '0;
          step_d             = STW'(LDW);
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          res_valid_d = 1'b1;
          res_rms_d   = root_q;
          res_lvl_d   = quo_q[LevelW-1:0];
          res_cnt_d   = blk_cnt_q;
          res_ovf_d   = blk_ovf_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACC;
      acc_sum_q   <= '0;
      acc_cnt_q   <= '0;
      acc_ovf_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_sum_q   <= acc_sum_d;
      acc_cnt_q   <= acc_cnt_d;
      acc_ovf_q   <= acc_ovf_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_cnt_q <= blk_cnt_d;
    blk_ovf_q <= blk_ovf_d;
    dvd_q     <= dvd_d;
    den_q     <= den_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    step_q    <= step_d;
    rrem_q    <= rrem_d;
    root_q    <= root_d;
    res_rms_q <= res_rms_d;
    res_lvl_q <= res_lvl_d;
    res_cnt_q <= res_cnt_d;
    res_ovf_q <= res_ovf_d;
  end

  assign cnt_ext = (CW + CountOutW)'(res_cnt_q);

  assign res_o.valid        = res_valid_q;
  assign res_o.rms_q8       = res_rms_q;
  assign res_o.level_q16    = res_lvl_q;
  assign res_o.sample_count = cnt_ext[CountOutW-1:0];
  assign res_o.overflowed   = res_ovf_q;

endmodule

`default_nettype wire

// ===== rtl/rlm_checker.sv =====
// ----------------------------------------------------------------------------
// rlm_checker
// Port-level checks of the level meter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rlm_checker import rlm_pkg::*; #(
  parameter int unsigned MAX_BLOCK = MaxBlockDflt
) (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_ready_i,
  input wire logic                 in_last_i,
  input wire logic                 out_valid_i,
  input wire logic                 out_ready_i,
  input wire logic [RmsW-1:0]      rms_q8_i,
  input wire logic [LevelW-1:0]    level_q16_i,
  input wire logic [CountOutW-1:0] sample_count_i,
  input wire logic                 overflowed_i
);

  logic [31:0] lvl_lo;
  logic [31:0] rms_sc;

  assign lvl_lo = 32'(level_q16_i) * 32'(LevelDiv);
  assign rms_sc = 32'(rms_q8_i) << LevelFracW;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  a_level_rel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (lvl_lo <= rms_sc) && (rms_sc < lvl_lo + 32'(LevelDiv)))
    else $error("level does not match rms");

  a_rms_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> rms_q8_i <= RmsW'(32768))
    else $error("rms out of range");

  a_ovf_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && overflowed_i |-> sample_count_i == CountOutW'(MAX_BLOCK))
    else $error("overflow with short count");

  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> !in_ready_i)
    else $error("input taken during block computation");

endmodule

bind block_rms_level_meter_core rlm_checker #(.MAX_BLOCK(MAX_BLOCK)) u_rlm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (smp_i.valid),
  .in_ready_i     (smp_i.ready),
  .in_last_i      (smp_i.last),
  .out_valid_i    (res_o.valid),
  .out_ready_i    (res_o.ready),
  .rms_q8_i       (res_o.rms_q8),
  .level_q16_i    (res_o.level_q16),
  .sample_count_i (res_o.sample_count),
  .overflowed_i   (res_o.overflowed)
);

`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for block_rms_level_meter_core. Sample words go in on
// the valid/ready input channel. A block ends on the word with last set. An
// in-bench model keeps the sum of squares, the count and the overflow flag.
// It queues the expected rms, level, count and overflow for each block. Each
// result word taken from the output is checked against the oldest entry.
// The stimulus has directed extremes, then a long full-scale block, then
// random blocks. The sender and the receiver idle at different rates over
// the run.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rlm_pkg::*;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned TailCycles    = 120;
  localparam int unsigned LongLen       = 300;

  typedef struct packed {
    logic [RmsW-1:0]      rms_q8;
    logic [LevelW-1:0]    level_q16;
    logic [CountOutW-1:0] sample_count;
    logic                 overflowed;
  } meter_word_t;

  logic clk;
  logic rst_n;

  rlm_smp_if smp ();
  rlm_res_if res ();

  block_rms_level_meter_core u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .smp_i (smp.sink),
    .res_o (res.source)
  );

  meter_word_t       pending_levels[$];
  longint unsigned   sq_sum;
  int unsigned       blk_count;
  bit                blk_ovf;
  int unsigned       gap_pct;
  int unsigned       stall_pct;
  int                errors;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 20; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  task automatic accumulate_sample(input logic signed [SampleW-1:0] s, input logic l);
    longint unsigned msq;
    longint unsigned rms;
    longint unsigned lvl;
    meter_word_t     w;
    if (blk_count < MaxBlockDflt) begin
      sq_sum += longint'(int'(s) * int'(s));
      blk_count++;
    end else begin
      blk_ovf = 1'b1;
    end
    if (l) begin
      rms = 0;
      if (blk_count != 0) begin
        msq = (sq_sum << MsqFracW) / blk_count;
        rms = floor_root(msq);
      end
      lvl = (rms << LevelFracW) / LevelDiv;
      w.rms_q8       = rms[RmsW-1:0];
      w.level_q16    = lvl[LevelW-1:0];
      w.sample_count = blk_count[CountOutW-1:0];
      w.overflowed   = blk_ovf;
      pending_levels.push_back(w);
      sq_sum    = 0;
      blk_count = 0;
      blk_ovf   = 1'b0;
    end
  endtask

  task automatic send_sample(input logic signed [SampleW-1:0] s, input logic l);
    while ($urandom_range(99) < gap_pct) begin
      smp.valid <= 1'b0;
      @(posedge clk);
    end
    smp.valid  <= 1'b1;
    smp.sample <= s;
    smp.last   <= l;
    do @(posedge clk); while (!smp.ready);
    accumulate_sample(s, l);
  endtask

  function automatic logic signed [SampleW-1:0] pick_sample();
    case ($urandom_range(7))
      0:       return -8'sd128;
      1:       return 8'sd127;
      2:       return SampleW'(int'($urandom_range(4)) - 2);
      default: return SampleW'($urandom_range(255));
    endcase
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic test_directed();
    gap_pct   = 10;
    stall_pct = 48;
    send_sample(-8'sd128, 1'b1);
    send_sample(8'sd127, 1'b1);
    send_sample(8'sd0, 1'b1);
    send_sample(-8'sd1, 1'b1);
    send_sample(8'sd1, 1'b1);
    send_sample(8'sd127, 1'b0);
    send_sample(-8'sd128, 1'b1);
    send_sample(-8'sd128, 1'b0);
    send_sample(-8'sd128, 1'b0);
    send_sample(-8'sd128, 1'b1);
    send_sample(8'sd85, 1'b0);
    send_sample(-8'sd86, 1'b1);
    send_sample(8'sd3, 1'b0);
    send_sample(-8'sd3, 1'b0);
    send_sample(8'sd64, 1'b0);
    send_sample(-8'sd64, 1'b1);
    send_sample(8'sd0, 1'b0);
    send_sample(8'sd0, 1'b0);
    send_sample(8'sd1, 1'b1);
  endtask

  task automatic test_long_blocks();
    gap_pct   = 10;
    stall_pct = 48;
    for (int unsigned i = 1; i <= LongLen; i++) send_sample(-8'sd128, i == LongLen);
  endtask

  task automatic test_random(input int unsigned gap, input int unsigned stall,
                             input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    int unsigned style;
    gap_pct   = gap;
    stall_pct = stall;
    sent      = 0;
    while (sent < n_items) begin
      style = $urandom_range(99);
      if (style < 80) len = $urandom_range(12, 1);
      else if (style < 95) len = $urandom_range(64, 13);
      else len = $urandom_range(200, 100);
      for (int unsigned i = 1; i <= len; i++) send_sample(pick_sample(), i == len);
      sent += len;
    end
  endtask

  initial begin
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    meter_word_t want;
    if (rst_n && res.valid && res.ready) begin
      if (pending_levels.size() == 0) begin
        $display("%0t: result word with none expected: rms %0d level %0d count %0d ovf %0d",
                 $time, res.rms_q8, res.level_q16, res.sample_count, res.overflowed);
        errors++;
      end else begin
        want = pending_levels.pop_front();
        check_field("rms_q8", want.rms_q8, res.rms_q8);
        check_field("level_q16", want.level_q16, res.level_q16);
        check_field("sample_count", want.sample_count, res.sample_count);
        check_field("overflowed", want.overflowed, res.overflowed);
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if ((smp.valid && smp.ready) || (res.valid && res.ready)) quiet = 0;
      else quiet++;
    end
    $display("block_rms_level_meter_core test failed");
    $finish;
  end

  initial begin
    errors     = 0;
    gap_pct    = 0;
    stall_pct  = 0;
    sq_sum     = 0;
    blk_count  = 0;
    blk_ovf    = 1'b0;
    rst_n      <= 1'b0;
    smp.valid  <= 1'b0;
    smp.sample <= '0;
    smp.last   <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_long_blocks();
    test_random(10, 48, 140);
    test_random(48, 10, 140);
    test_random(0, 0, 140);
    smp.valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (errors == 0) begin
      $display("block_rms_level_meter_core test passed");
    end else begin
      $display("block_rms_level_meter_core test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rlm_pkg.sv
rtl/rlm_intf.sv
rtl/block_rms_level_meter_core.sv
rtl/rlm_checker.sv
bench/tb.sv
